// ===== design/slc_pkg.sv =====
package slc_pkg;

  localparam int POS_BITS = 24;
  localparam int MAX_RES = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [3:0] {
    M_IDLE       = 4'd0,
    M_SLASH      = 4'd1,
    M_COMMENT    = 4'd2,
    M_IDENT      = 4'd3,
    M_NUMBER     = 4'd4,
    M_STRING     = 4'd5,
    M_EQ         = 4'd6,
    M_TYPE_FIRST = 4'd7,
    M_TYPE_RUN   = 4'd8,
    M_FN_PARAMS  = 4'd9,
    M_FN_TAIL    = 4'd10,
    M_BODY_OPEN  = 4'd11,
    M_BODY       = 4'd12
  } mode_t;

  typedef enum logic [3:0] {
    K_IDENT     = 4'd0,
    K_LITERAL   = 4'd1,
    K_TYPE      = 4'd2,
    K_FNTYPE    = 4'd3,
    K_SCOPE     = 4'd4,
    K_SCOPE_END = 4'd5,
    K_SEP       = 4'd6,
    K_ASSIGN    = 4'd7,
    K_SEMI      = 4'd8,
    K_KEYWORD   = 4'd9,
    K_TYPEDEF   = 4'd10
  } kind_t;

  typedef enum logic [1:0] {
    E_NONE       = 2'd0,
    E_END        = 2'd1,
    E_CHAR       = 2'd2,
    E_TYPE_NAME  = 2'd3
  } err_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    kind_t kind;
    pos_t  start;
    pos_t  len;
    err_t  code;
    logic  done;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] r;
    logic [1:0]         count;
  } bundle_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || c == CH_UNDER;
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return is_digit(c) || c == CH_DOT;
  endfunction

  function automatic res_t mk_res(input kind_t kind, input pos_t start, input pos_t len,
                                  input err_t code, input logic done);
    res_t r;
    r.kind  = kind;
    r.start = start;
    r.len   = len;
    r.code  = code;
    r.done  = done;
    return r;
  endfunction

  function automatic bundle_t add_res(input bundle_t b, input res_t r);
    bundle_t o;
    o = b;
    if (b.count < 2'(MAX_RES)) begin
      o.r[b.count] = r;
      o.count = b.count + 2'd1;
    end
    return o;
  endfunction

endpackage

// ===== design/slc_front.sv =====
module slc_front
  import slc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] char_code,
  input  logic       end_of_source,
  output logic       res_valid,
  output bundle_t    res_bundle
);

  mode_t mode, mode_next;
  pos_t  pos, pos_next;
  pos_t  token_start, token_start_next;
  logic  star_seen, star_seen_next;
  logic  escape_pending, escape_pending_next;
  logic  halted, halted_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= M_IDLE;
      pos            <= '0;
      token_start    <= '0;
      star_seen      <= 1'b0;
      escape_pending <= 1'b0;
      halted         <= 1'b0;
    end else if (take) begin
      mode           <= mode_next;
      pos            <= pos_next;
      token_start    <= token_start_next;
      star_seen      <= star_seen_next;
      escape_pending <= escape_pending_next;
      halted         <= halted_next;
    end
  end

  always_comb begin
    logic [7:0] x;
    logic       again;
    pos_t       span;
    pos_t       len_end;
    bundle_t    b;

    x       = char_code;
    again   = 1'b0;
    span    = pos - token_start;
    len_end = pos + pos_t'(1);
    b       = '0;

    mode_next           = mode;
    pos_next            = pos + pos_t'(1);
    token_start_next    = token_start;
    star_seen_next      = star_seen;
    escape_pending_next = escape_pending;
    halted_next         = halted;

    if (!halted) begin
      unique case (mode)
        M_IDLE: again = 1'b1;
        M_SLASH: begin
          if (x == CH_STAR) begin
            mode_next      = M_COMMENT;
            star_seen_next = 1'b1;
          end else begin
            again = 1'b1;
          end
        end
        M_COMMENT: begin
          if (x == CH_NUL) begin
            b = add_res(b, mk_res(K_IDENT, pos, '0, E_END, 1'b0));
            halted_next = 1'b1;
          end else if (star_seen && x == CH_SLASH) begin
            star_seen_next = 1'b0;
            again = 1'b1;
          end else begin
            star_seen_next = (x == CH_STAR);
          end
        end
        M_IDENT: begin
          if (is_word(x)) begin
            mode_next = M_IDENT;
          end else if (x == CH_NUL) begin
            b = add_res(b, mk_res(K_IDENT, pos, '0, E_END, 1'b0));
            halted_next = 1'b1;
          end else if (x == CH_BANG) begin
            b = add_res(b, mk_res(K_KEYWORD, token_start, span, E_NONE, 1'b0));
            mode_next = M_IDLE;
          end else begin
            b = add_res(b, mk_res(K_IDENT, token_start, span, E_NONE, 1'b0));
            again = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_num(x)) begin
            mode_next = M_NUMBER;
          end else if (x == CH_NUL) begin
            b = add_res(b, mk_res(K_IDENT, pos, '0, E_END, 1'b0));
            halted_next = 1'b1;
          end else begin
            b = add_res(b, mk_res(K_LITERAL, token_start, span, E_NONE, 1'b0));
            again = 1'b1;
          end
        end
        M_STRING: begin
          if (x == CH_NUL) begin
            b = add_res(b, mk_res(K_IDENT, pos, '0, E_END, 1'b0));
            halted_next = 1'b1;
          end else if (escape_pending) begin
            escape_pending_next = 1'b0;
          end else if (x == CH_BSLASH) begin
            escape_pending_next = 1'b1;
          end else if (x == CH_QUOTE) begin
            b = add_res(b, mk_res(K_LITERAL, token_start, span + pos_t'(1), E_NONE, 1'b0));
            mode_next = M_IDLE;
          end
        end
        M_EQ: begin
          if (x == CH_SEMI) begin
            b = add_res(b, mk_res(K_IDENT, pos, '0, E_CHAR, 1'b0));
            halted_next = 1'b1;
          end else begin
            b = add_res(b, mk_res(K_ASSIGN, token_start, pos_t'(1), E_NONE, 1'b0));
            if (is_num(x)) begin
              mode_next        = M_NUMBER;
              token_start_next = pos;
            end else begin
              again = 1'b1;
            end
          end
        end
        M_TYPE_FIRST: begin
          if (x == CH_LPAREN) begin
            mode_next        = M_FN_PARAMS;
            token_start_next = pos;
          end else if (is_letter(x)) begin
            mode_next        = M_TYPE_RUN;
            token_start_next = pos;
          end else begin
            b = add_res(b, mk_res(K_IDENT, pos, '0, E_TYPE_NAME, 1'b0));
            halted_next = 1'b1;
          end
        end
        M_TYPE_RUN: begin
          if (is_word(x)) begin
            mode_next = M_TYPE_RUN;
          end else if (x == CH_NUL) begin
            b = add_res(b, mk_res(K_IDENT, pos, '0, E_END, 1'b0));
            halted_next = 1'b1;
          end else begin
            b = add_res(b, mk_res(K_TYPE, token_start, span, E_NONE, 1'b0));
            again = 1'b1;
          end
        end
        M_FN_PARAMS: begin
          if (x == CH_NUL) begin
            b = add_res(b, mk_res(K_IDENT, pos, '0, E_END, 1'b0));
            halted_next = 1'b1;
          end else if (x == CH_RPAREN) begin
            mode_next = M_FN_TAIL;
          end
        end
        M_FN_TAIL: begin
          if (x == CH_NUL) begin
            b = add_res(b, mk_res(K_IDENT, pos, '0, E_END, 1'b0));
            halted_next = 1'b1;
          end else if (x == CH_SEMI) begin
            b = add_res(b, mk_res(K_FNTYPE, token_start, span, E_NONE, 1'b0));
            b = add_res(b, mk_res(K_SEMI, pos, pos_t'(1), E_NONE, 1'b0));
            mode_next = M_IDLE;
          end else if (x == CH_EQ) begin
            b = add_res(b, mk_res(K_FNTYPE, token_start, span, E_NONE, 1'b0));
            b = add_res(b, mk_res(K_ASSIGN, pos, pos_t'(1), E_NONE, 1'b0));
            mode_next = M_BODY_OPEN;
          end
        end
        M_BODY_OPEN: begin
          if (x == CH_NUL) begin
            b = add_res(b, mk_res(K_IDENT, pos, '0, E_END, 1'b0));
            halted_next = 1'b1;
          end else if (x == CH_LBRACE) begin
            b = add_res(b, mk_res(K_SCOPE, pos, pos_t'(1), E_NONE, 1'b0));
            mode_next = M_BODY;
          end
        end
        M_BODY: begin
          if (x == CH_NUL) begin
            b = add_res(b, mk_res(K_IDENT, pos, '0, E_END, 1'b0));
            halted_next = 1'b1;
          end else if (x == CH_RBRACE) begin
            b = add_res(b, mk_res(K_SCOPE_END, pos, pos_t'(1), E_NONE, 1'b0));
            mode_next = M_IDLE;
          end
        end
        default: again = 1'b1;
      endcase

      // re-examine the byte at top level
      if (again) begin
        mode_next = M_IDLE;
        if (x == CH_SLASH) begin
          mode_next = M_SLASH;
        end else if (is_letter(x) || x == CH_UNDER) begin
          mode_next        = M_IDENT;
          token_start_next = pos;
        end else if (is_num(x)) begin
          mode_next        = M_NUMBER;
          token_start_next = pos;
        end else if (x == CH_QUOTE) begin
          mode_next           = M_STRING;
          token_start_next    = pos;
          escape_pending_next = 1'b0;
        end else if (x == CH_COLON) begin
          b = add_res(b, mk_res(K_SEP, pos, pos_t'(1), E_NONE, 1'b0));
          mode_next = M_TYPE_FIRST;
        end else if (x == CH_LBRACE) begin
          b = add_res(b, mk_res(K_SCOPE, pos, pos_t'(1), E_NONE, 1'b0));
        end else if (x == CH_RBRACE) begin
          b = add_res(b, mk_res(K_SCOPE_END, pos, pos_t'(1), E_NONE, 1'b0));
        end else if (x == CH_SEMI) begin
          b = add_res(b, mk_res(K_SEMI, pos, pos_t'(1), E_NONE, 1'b0));
        end else if (x == CH_HASH) begin
          b = add_res(b, mk_res(K_TYPEDEF, pos, pos_t'(1), E_NONE, 1'b0));
        end else if (x == CH_EQ) begin
          mode_next        = M_EQ;
          token_start_next = pos;
        end else begin
          b = add_res(b, mk_res(K_IDENT, pos, '0, E_CHAR, 1'b0));
          halted_next = 1'b1;
        end
      end

      // close the source
      if (!halted_next && end_of_source) begin
        if (mode_next == M_IDLE || mode_next == M_SLASH) begin
          b = add_res(b, mk_res(K_IDENT, len_end, '0, E_NONE, 1'b1));
        end else if (mode_next == M_EQ) begin
          b = add_res(b, mk_res(K_ASSIGN, token_start_next, pos_t'(1), E_NONE, 1'b0));
          b = add_res(b, mk_res(K_IDENT, len_end, '0, E_NONE, 1'b1));
        end else if (mode_next == M_TYPE_FIRST) begin
          b = add_res(b, mk_res(K_IDENT, len_end, '0, E_TYPE_NAME, 1'b0));
        end else begin
          b = add_res(b, mk_res(K_IDENT, len_end, '0, E_END, 1'b0));
        end
      end
    end

    if (end_of_source) begin
      mode_next           = M_IDLE;
      pos_next            = '0;
      token_start_next    = '0;
      star_seen_next      = 1'b0;
      escape_pending_next = 1'b0;
      halted_next         = 1'b0;
    end

    res_bundle = b;
    res_valid  = take && (b.count != 2'd0);
  end

endmodule

// ===== design/slc_queue.sv =====
module slc_queue
  import slc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  bundle_t wr_data,
  output logic    full,
  input  logic    rd_en,
  output logic    rd_valid,
  output bundle_t rd_data
);

  bundle_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_wr;
  logic                do_rd;

  assign full     = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (QUEUE_AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

// ===== design/slc_back.sv =====
module slc_back
  import slc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  bundle_t     q_data,
  output logic        q_take,
  input  logic        pop,
  output logic        empty,
  output logic [3:0]  token_kind,
  output logic [23:0] start_offset,
  output logic [23:0] token_length,
  output logic        is_error,
  output logic [1:0]  error_code,
  output logic        source_done,
  output logic        last_of_run
);

  bundle_t    cur;
  logic [1:0] idx;
  logic       busy;
  res_t       r;
  logic       at_last;

  assign r       = cur.r[idx];
  assign at_last = (idx == cur.count - 2'd1);
  assign q_take  = !busy || (pop && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_take) begin
      busy <= q_valid;
      idx  <= '0;
    end else if (pop) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      cur <= q_data;
    end
  end

  assign empty        = !busy;
  assign token_kind   = r.kind;
  assign start_offset = 24'(r.start);
  assign token_length = 24'(r.len);
  assign is_error     = (r.code != E_NONE);
  assign error_code   = r.code;
  assign source_done  = r.done;
  assign last_of_run  = at_last;

endmodule

// ===== design/source_lexer_char_stream.sv =====
// Channel   Handshake          Beat
// input     push / full        char_code, end_of_source
// results   pop / empty        token_kind, start_offset, token_length, is_error,
//                              error_code, source_done, last_of_run
//
// The front lexes one byte per cycle and writes all results of that byte into a
// four-entry queue as one bundle; the back hands them out one per cycle.
// Input rate is one byte per cycle while the queue has room; output rate is one
// result per cycle while pop is held, so the results of one byte leave one at a time.
// rst is synchronous and clears the lexer, the queue and the output stage.
// A byte's results pass through a queue entry and then the back's bundle register to the ports.
module source_lexer_char_stream
  import slc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code,
  input  logic        end_of_source,
  input  logic        pop,
  output logic        empty,
  output logic [3:0]  token_kind,
  output logic [23:0] start_offset,
  output logic [23:0] token_length,
  output logic        is_error,
  output logic [1:0]  error_code,
  output logic        source_done,
  output logic        last_of_run
);

  logic    take;
  logic    fr_valid;
  bundle_t fr_bundle;
  logic    q_valid;
  bundle_t q_data;
  logic    q_take;

  assign take = push && !full;

  slc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .char_code     (char_code),
    .end_of_source (end_of_source),
    .res_valid     (fr_valid),
    .res_bundle    (fr_bundle)
  );

  slc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fr_valid),
    .wr_data  (fr_bundle),
    .full     (full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  slc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_take       (q_take),
    .pop          (pop),
    .empty        (empty),
    .token_kind   (token_kind),
    .start_offset (start_offset),
    .token_length (token_length),
    .is_error     (is_error),
    .error_code   (error_code),
    .source_done  (source_done),
    .last_of_run  (last_of_run)
  );

endmodule

// ===== tb/source_lexer_char_stream_tb.sv =====
module source_lexer_char_stream_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RX_HOLD_CYCLES = 250;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [7:0] ch;
    logic       eos;
    int         gap;
    logic       drain;
    logic       hold_rx;
  } src_byte_t;

  typedef struct {
    kind_t kind;
    pos_t  start;
    pos_t  len;
    err_t  code;
    logic  done;
    logic  last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_code = 8'h00;
  logic        end_of_source = 1'b0;
  logic        pop = 1'b0;
  logic        empty;
  logic [3:0]  token_kind;
  logic [23:0] start_offset;
  logic [23:0] token_length;
  logic        is_error;
  logic [1:0]  error_code;
  logic        source_done;
  logic        last_of_run;

  src_byte_t  byte_q[$];
  token_t     token_q[$];
  token_t     fresh[$];
  logic [7:0] src_text[$];

  mode_t lx_mode;
  pos_t  lx_pos;
  pos_t  lx_start;
  logic  lx_star;
  logic  lx_esc;
  logic  lx_halt;

  logic hold_rx_now = 1'b0;
  int   hold_left = 0;
  int   tx_wait = 0;
  int   rx_wait = 0;
  logic rx_calm = 1'b0;
  int   beats = 0;
  int   cycles = 0;
  logic failed = 1'b0;

  source_lexer_char_stream u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .char_code    (char_code),
    .end_of_source(end_of_source),
    .pop          (pop),
    .empty        (empty),
    .token_kind   (token_kind),
    .start_offset (start_offset),
    .token_length (token_length),
    .is_error     (is_error),
    .error_code   (error_code),
    .source_done  (source_done),
    .last_of_run  (last_of_run)
  );

  always #1 clk = ~clk;

  function automatic logic alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic decimal(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic name_char(logic [7:0] c);
    return alpha(c) || decimal(c) || c == CH_UNDER;
  endfunction

  function automatic logic numeric(logic [7:0] c);
    return decimal(c) || c == CH_DOT;
  endfunction

  function automatic void lex_clear();
    lx_mode = M_IDLE;
    lx_pos = '0;
    lx_start = '0;
    lx_star = 1'b0;
    lx_esc = 1'b0;
    lx_halt = 1'b0;
  endfunction

  function automatic void emit(kind_t kind, pos_t start, pos_t len, err_t code, logic done);
    token_t t;
    if (fresh.size() < MAX_RES) begin
      t.kind = kind;
      t.start = start;
      t.len = len;
      t.code = code;
      t.done = done;
      t.last = 1'b0;
      fresh.insert(fresh.size(), t);
    end
  endfunction

  function automatic void halt_with(err_t code, pos_t at);
    emit(K_IDENT, at, '0, code, 1'b0);
    lx_halt = 1'b1;
  endfunction

  // Work out the tokens that one source byte releases.
  task automatic lex_byte(input logic [7:0] c, input logic eos);
    pos_t p;
    int   pass;
    logic again;
    p = lx_pos;
    fresh.delete();
    if (lx_halt) begin
      if (eos) lex_clear();
      else lx_pos = p + pos_t'(1);
      return;
    end
    again = 1'b1;
    pass = 0;
    while (again && pass < 3) begin
      again = 1'b0;
      pass++;
      case (lx_mode)
        M_IDLE: begin
          if (c == CH_SLASH) lx_mode = M_SLASH;
          else if (alpha(c) || c == CH_UNDER) begin
            lx_mode = M_IDENT;
            lx_start = p;
          end else if (numeric(c)) begin
            lx_mode = M_NUMBER;
            lx_start = p;
          end else if (c == CH_QUOTE) begin
            lx_mode = M_STRING;
            lx_start = p;
            lx_esc = 1'b0;
          end else if (c == CH_COLON) begin
            emit(K_SEP, p, pos_t'(1), E_NONE, 1'b0);
            lx_mode = M_TYPE_FIRST;
          end else if (c == CH_LBRACE) emit(K_SCOPE, p, pos_t'(1), E_NONE, 1'b0);
          else if (c == CH_RBRACE) emit(K_SCOPE_END, p, pos_t'(1), E_NONE, 1'b0);
          else if (c == CH_SEMI) emit(K_SEMI, p, pos_t'(1), E_NONE, 1'b0);
          else if (c == CH_HASH) emit(K_TYPEDEF, p, pos_t'(1), E_NONE, 1'b0);
          else if (c == CH_EQ) begin
            lx_mode = M_EQ;
            lx_start = p;
          end else halt_with(E_CHAR, p);
        end
        M_SLASH: begin
          if (c == CH_STAR) begin
            lx_mode = M_COMMENT;
            lx_star = 1'b1;
          end else begin
            lx_mode = M_IDLE;
            again = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == CH_NUL) halt_with(E_END, p);
          else if (lx_star && c == CH_SLASH) begin
            lx_star = 1'b0;
            lx_mode = M_IDLE;
            again = 1'b1;
          end else lx_star = (c == CH_STAR);
        end
        M_IDENT: begin
          if (name_char(c)) begin
          end else if (c == CH_NUL) halt_with(E_END, p);
          else if (c == CH_BANG) begin
            emit(K_KEYWORD, lx_start, p - lx_start, E_NONE, 1'b0);
            lx_mode = M_IDLE;
          end else begin
            emit(K_IDENT, lx_start, p - lx_start, E_NONE, 1'b0);
            lx_mode = M_IDLE;
            again = 1'b1;
          end
        end
        M_NUMBER: begin
          if (numeric(c)) begin
          end else if (c == CH_NUL) halt_with(E_END, p);
          else begin
            emit(K_LITERAL, lx_start, p - lx_start, E_NONE, 1'b0);
            lx_mode = M_IDLE;
            again = 1'b1;
          end
        end
        M_STRING: begin
          if (c == CH_NUL) halt_with(E_END, p);
          else if (lx_esc) lx_esc = 1'b0;
          else if (c == CH_BSLASH) lx_esc = 1'b1;
          else if (c == CH_QUOTE) begin
            emit(K_LITERAL, lx_start, p - lx_start + pos_t'(1), E_NONE, 1'b0);
            lx_mode = M_IDLE;
          end
        end
        M_EQ: begin
          if (c == CH_SEMI) halt_with(E_CHAR, p);
          else begin
            emit(K_ASSIGN, lx_start, pos_t'(1), E_NONE, 1'b0);
            if (numeric(c)) begin
              lx_mode = M_NUMBER;
              lx_start = p;
            end else begin
              lx_mode = M_IDLE;
              again = 1'b1;
            end
          end
        end
        M_TYPE_FIRST: begin
          if (c == CH_LPAREN) begin
            lx_mode = M_FN_PARAMS;
            lx_start = p;
          end else if (alpha(c)) begin
            lx_mode = M_TYPE_RUN;
            lx_start = p;
          end else halt_with(E_TYPE_NAME, p);
        end
        M_TYPE_RUN: begin
          if (name_char(c)) begin
          end else if (c == CH_NUL) halt_with(E_END, p);
          else begin
            emit(K_TYPE, lx_start, p - lx_start, E_NONE, 1'b0);
            lx_mode = M_IDLE;
            again = 1'b1;
          end
        end
        M_FN_PARAMS: begin
          if (c == CH_NUL) halt_with(E_END, p);
          else if (c == CH_RPAREN) lx_mode = M_FN_TAIL;
        end
        M_FN_TAIL: begin
          if (c == CH_NUL) halt_with(E_END, p);
          else if (c == CH_SEMI) begin
            emit(K_FNTYPE, lx_start, p - lx_start, E_NONE, 1'b0);
            emit(K_SEMI, p, pos_t'(1), E_NONE, 1'b0);
            lx_mode = M_IDLE;
          end else if (c == CH_EQ) begin
            emit(K_FNTYPE, lx_start, p - lx_start, E_NONE, 1'b0);
            emit(K_ASSIGN, p, pos_t'(1), E_NONE, 1'b0);
            lx_mode = M_BODY_OPEN;
          end
        end
        M_BODY_OPEN: begin
          if (c == CH_NUL) halt_with(E_END, p);
          else if (c == CH_LBRACE) begin
            emit(K_SCOPE, p, pos_t'(1), E_NONE, 1'b0);
            lx_mode = M_BODY;
          end
        end
        M_BODY: begin
          if (c == CH_NUL) halt_with(E_END, p);
          else if (c == CH_RBRACE) begin
            emit(K_SCOPE_END, p, pos_t'(1), E_NONE, 1'b0);
            lx_mode = M_IDLE;
          end
        end
        default: begin
          lx_mode = M_IDLE;
          again = 1'b1;
        end
      endcase
    end
    if (!lx_halt && eos) begin
      case (lx_mode)
        M_IDLE, M_SLASH: emit(K_IDENT, p + pos_t'(1), '0, E_NONE, 1'b1);
        M_EQ: begin
          emit(K_ASSIGN, lx_start, pos_t'(1), E_NONE, 1'b0);
          emit(K_IDENT, p + pos_t'(1), '0, E_NONE, 1'b1);
        end
        M_TYPE_FIRST: halt_with(E_TYPE_NAME, p + pos_t'(1));
        default: halt_with(E_END, p + pos_t'(1));
      endcase
    end
    if (eos) lex_clear();
    else lx_pos = p + pos_t'(1);
    if (fresh.size() != 0) fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[i]) token_q.insert(token_q.size(), fresh[i]);
  endtask

  function automatic void put_char(logic [7:0] c);
    src_text.insert(src_text.size(), c);
  endfunction

  function automatic logic [7:0] pick_text(logic [7:0] skip_a, logic [7:0] skip_b);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == skip_a || c == skip_b);
    return c;
  endfunction

  task automatic add_name(logic allow_under);
    if (allow_under && $urandom_range(0, 4) == 0) put_char(CH_UNDER);
    else if ($urandom_range(0, 1) == 0) put_char(8'h61 + 8'($urandom_range(0, 25)));
    else put_char(8'h41 + 8'($urandom_range(0, 25)));
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 3))
        0: put_char(8'h61 + 8'($urandom_range(0, 25)));
        1: put_char(8'h41 + 8'($urandom_range(0, 25)));
        2: put_char(8'h30 + 8'($urandom_range(0, 9)));
        default: put_char(CH_UNDER);
      endcase
    end
  endtask

  task automatic add_number();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 4) == 0) put_char(CH_DOT);
      else put_char(8'h30 + 8'($urandom_range(0, 9)));
    end
  endtask

  // Mostly well-formed token runs, with some noise and cut-off endings.
  task automatic build_source();
    int k;
    src_text.delete();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 15))
        0, 1: add_name(1'b1);
        2: begin
          add_name(1'b1);
          put_char(CH_BANG);
        end
        3: add_number();
        4, 5: begin
          put_char(CH_QUOTE);
          repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 4) == 0) begin
              put_char(CH_BSLASH);
              put_char(pick_text(CH_NUL, CH_NUL));
            end else put_char(pick_text(CH_QUOTE, CH_BSLASH));
          end
          put_char(CH_QUOTE);
        end
        6, 7: begin
          case ($urandom_range(0, 3))
            0: put_char(CH_LBRACE);
            1: put_char(CH_RBRACE);
            2: put_char(CH_SEMI);
            default: put_char(CH_HASH);
          endcase
        end
        8: begin
          put_char(CH_EQ);
          if ($urandom_range(0, 1) == 0) add_number();
        end
        9: begin
          put_char(CH_COLON);
          add_name(1'b0);
        end
        10, 11: begin
          put_char(CH_COLON);
          put_char(CH_LPAREN);
          repeat ($urandom_range(0, 4)) put_char(pick_text(CH_RPAREN, CH_NUL));
          put_char(CH_RPAREN);
          repeat ($urandom_range(0, 2)) put_char(pick_text(CH_SEMI, CH_EQ));
          if ($urandom_range(0, 1) == 0) put_char(CH_SEMI);
          else begin
            put_char(CH_EQ);
            repeat ($urandom_range(0, 2)) put_char(pick_text(CH_LBRACE, CH_NUL));
            put_char(CH_LBRACE);
            repeat ($urandom_range(0, 5)) put_char(pick_text(CH_RBRACE, CH_NUL));
            put_char(CH_RBRACE);
          end
        end
        12, 13: begin
          put_char(CH_SLASH);
          if ($urandom_range(0, 3) != 0) begin
            put_char(CH_STAR);
            repeat ($urandom_range(0, 5)) put_char(pick_text(CH_SLASH, CH_NUL));
            put_char(CH_STAR);
            put_char(CH_SLASH);
          end
        end
        default: begin
          if ($urandom_range(0, 1) == 0) put_char(CH_NUL);
          else put_char(8'($urandom_range(0, 255)));
        end
      endcase
    end
    if ($urandom_range(0, 7) == 0 && src_text.size() > 1) begin
      k = $urandom_range(1, (src_text.size() > 3) ? 3 : src_text.size() - 1);
      repeat (k) void'(src_text.pop_back());
    end
  endtask

  task automatic load_string(string s);
    src_text.delete();
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  task automatic queue_text(logic calm, logic drain_first, logic hold_first);
    src_byte_t b;
    foreach (src_text[i]) begin
      b.ch = src_text[i];
      b.eos = (i == src_text.size() - 1);
      b.gap = calm ? 0 : int'($urandom_range(0, 15));
      b.drain = drain_first && i == 0;
      b.hold_rx = hold_first && i == 0;
      byte_q.insert(byte_q.size(), b);
    end
  endtask

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      failed = 1'b1;
    end
  endfunction

  // Source byte driver.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      tx_wait = 0;
    end else if (!(push && full)) begin
      if (push) begin
        lex_byte(char_code, end_of_source);
        if (byte_q.size() != 0) tx_wait = byte_q[0].gap;
      end
      if (tx_wait != 0) begin
        tx_wait--;
        push <= 1'b0;
      end else if (byte_q.size() != 0 && !(byte_q[0].drain && token_q.size() != 0)) begin
        push <= 1'b1;
        char_code <= byte_q[0].ch;
        end_of_source <= byte_q[0].eos;
        hold_rx_now <= byte_q[0].hold_rx;
        void'(byte_q.pop_front());
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started by a marked byte.
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (push && !full && hold_rx_now) hold_left <= RX_HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Token monitor.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_wait = 0;
    end else begin
      if (pop && !empty) begin
        if (token_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual kind %0h start %0h len %0h",
                   $time, token_kind, start_offset, token_length);
          failed = 1'b1;
        end else begin
          check_field("kind", 32'(token_q[0].kind), 32'(token_kind));
          check_field("start", 32'(token_q[0].start), 32'(start_offset));
          check_field("length", 32'(token_q[0].len), 32'(token_length));
          check_field("error flag", 32'(token_q[0].code != E_NONE), 32'(is_error));
          check_field("error code", 32'(token_q[0].code), 32'(error_code));
          check_field("done", 32'(token_q[0].done), 32'(source_done));
          check_field("last", 32'(token_q[0].last), 32'(last_of_run));
          void'(token_q.pop_front());
        end
        beats++;
        if (beats % 32 == 0) rx_calm = ($urandom_range(0, 2) == 0);
        rx_wait = rx_calm ? 0 : int'($urandom_range(0, 15));
      end
      if (hold_left != 0) pop <= 1'b0;
      else if (rx_wait != 0) begin
        rx_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    lex_clear();
    load_string("/*/_a!{}#/x");
    queue_text(1'b0, 1'b0, 1'b0);
    load_string("\"\\\"\":(,)={}=");
    queue_text(1'b0, 1'b0, 1'b0);
    load_string(":9");
    queue_text(1'b1, 1'b0, 1'b0);
    load_string("=;");
    queue_text(1'b0, 1'b0, 1'b0);
    load_string(" ");
    queue_text(1'b0, 1'b0, 1'b0);
    // Fill the result queue behind a stalled receiver, then drain.
    load_string("{}#;{}#;{}#;");
    queue_text(1'b1, 1'b0, 1'b1);
    load_string("x=1;");
    queue_text(1'b0, 1'b1, 1'b0);
    while (byte_q.size() < 230) begin
      build_source();
      queue_text($urandom_range(0, 2) == 0, byte_q.size() == 40 || $urandom_range(0, 9) == 0,
                 1'b0);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (byte_q.size() != 0 || push) @(posedge clk);
    while (token_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!failed) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/slc_pkg.sv
design/slc_front.sv
design/slc_queue.sv
design/slc_back.sv
design/source_lexer_char_stream.sv
tb/source_lexer_char_stream_tb.sv
